### rtl/core/nsfp_pkg.sv
// Package for the NMEA sentence field parser.
// Holds character codes, field ids, the sentence kind type and helper functions.
// No dependencies.
package nsfp_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;

  localparam logic [23:0] FMT_RMC = 24'h524D43;
  localparam logic [23:0] FMT_GLL = 24'h474C4C;

  localparam logic [3:0] FID_ADDRESS  = 4'd0;
  localparam logic [3:0] FID_TIME     = 4'd1;
  localparam logic [3:0] FID_STATUS   = 4'd2;
  localparam logic [3:0] FID_LAT      = 4'd3;
  localparam logic [3:0] FID_NS       = 4'd4;
  localparam logic [3:0] FID_LON      = 4'd5;
  localparam logic [3:0] FID_EW       = 4'd6;
  localparam logic [3:0] FID_POSMODE  = 4'd12;
  localparam logic [3:0] FID_LAST_RMC = 4'd13;
  localparam logic [3:0] FID_NONE     = 4'd15;

  localparam logic [3:0] FIELD_COUNT_MAX = 4'd15;
  localparam logic [2:0] ADDR_FMT_START  = 3'd2;
  localparam logic [2:0] ADDR_LAST_POS   = 3'd4;
  localparam logic [2:0] ADDR_LEN        = 3'd5;
  localparam logic [6:0] CSUM_DIGITS     = 7'd2;
  localparam logic [6:0] CHAR_COUNT_MAX  = 7'd127;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_RMC     = 2'd1,
    KIND_GLL     = 2'd2
  } kind_t;

  typedef struct packed {
    logic [3:0] field_id;
    logic [5:0] char_index;
    logic [7:0] char_value;
    logic       sentence_done;
    logic [1:0] sentence_kind;
    logic [7:0] received_checksum;
    logic [7:0] computed_checksum;
    logic       overflow_seen;
  } result_t;

  // Returns {valid, digit value} for an ASCII hex digit of either case.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  // GLL field order mapped onto the RMC field names.
  function automatic logic [3:0] gll_field_id(input logic [3:0] f);
    logic [3:0] id;
    case (f)
      4'd0:    id = FID_ADDRESS;
      4'd1:    id = FID_LAT;
      4'd2:    id = FID_NS;
      4'd3:    id = FID_LON;
      4'd4:    id = FID_EW;
      4'd5:    id = FID_TIME;
      4'd6:    id = FID_STATUS;
      4'd7:    id = FID_POSMODE;
      default: id = FID_NONE;
    endcase
    return id;
  endfunction

  function automatic logic [3:0] map_field(input logic [3:0] f, input kind_t kind);
    logic [3:0] id;
    id = FID_NONE;
    if (f == FID_ADDRESS) begin
      id = FID_ADDRESS;
    end else if (kind == KIND_RMC) begin
      id = (f <= FID_LAST_RMC) ? f : FID_NONE;
    end else if (kind == KIND_GLL) begin
      id = gll_field_id(f);
    end
    return id;
  endfunction

endpackage

### rtl/core/nsfp_in_if.sv
// Byte input channel of the NMEA sentence field parser.
// Carries valid, ready and one received character. No dependencies.
interface nsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/core/nsfp_out_if.sv
// Result channel of the NMEA sentence field parser.
// Carries valid, ready and the field character or end-of-sentence payload.
interface nsfp_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] field_id;
  logic [5:0] char_index;
  logic [7:0] char_value;
  logic       sentence_done;
  logic [1:0] sentence_kind;
  logic [7:0] received_checksum;
  logic [7:0] computed_checksum;
  logic       overflow_seen;

  modport source (
    output valid, output field_id, output char_index, output char_value,
    output sentence_done, output sentence_kind, output received_checksum,
    output computed_checksum, output overflow_seen, input ready
  );
  modport sink (
    input valid, input field_id, input char_index, input char_value,
    input sentence_done, input sentence_kind, input received_checksum,
    input computed_checksum, input overflow_seen, output ready
  );
endinterface

### rtl/core/nmea_sentence_field_parser_core.sv
// NMEA 0183 sentence field parser: one received byte per transaction in, tagged
// field characters and an end-of-sentence summary out. Uses nsfp_pkg and the
// nsfp_in_if / nsfp_out_if channel interfaces.
// A result is registered in the output register, or in the skid stage while the output is stalled.
// Throughput: one byte per cycle while ready is high; the parser state updates for each accepted byte.
// A two-entry output register and skid stage hold results; ready drops only when both are full.
// Reset (rst_n low, synchronous) clears the sentence state and empties the output stage.
module nmea_sentence_field_parser_core
  import nsfp_pkg::*;
#(
  parameter int FIELD_MAX_CHARS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  nsfp_in_if.sink    in_chan,
  nsfp_out_if.source out_chan
);

  localparam logic [6:0] FieldMax = 7'(FIELD_MAX_CHARS);

  logic        in_sentence_r, in_sentence_nxt;
  logic [3:0]  field_count_r, field_count_nxt;
  logic [6:0]  char_count_r, char_count_nxt;
  logic [2:0]  position_count_r, position_count_nxt;
  logic [23:0] format_chars_r, format_chars_nxt;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  xor_acc_r, xor_acc_nxt;
  logic        after_star_r, after_star_nxt;
  logic [7:0]  rx_sum_r, rx_sum_nxt;
  logic        overflow_r, overflow_nxt;

  logic        accept;
  logic [7:0]  c;
  logic [4:0]  hex;
  logic [3:0]  fid;
  logic [23:0] fmt_shift;
  logic        res_valid;
  result_t     res;

  result_t     out_r, skid_r;
  logic        out_valid_r, skid_valid_r;
  logic        out_free;

  assign in_chan.ready = !skid_valid_r;
  assign accept        = in_chan.valid && in_chan.ready;
  assign c             = in_chan.rx_byte;
  assign hex           = hex_decode(c);
  assign fmt_shift     = {format_chars_r[15:0], c};

  always_comb begin
    in_sentence_nxt    = in_sentence_r;
    field_count_nxt    = field_count_r;
    char_count_nxt     = char_count_r;
    position_count_nxt = position_count_r;
    format_chars_nxt   = format_chars_r;
    kind_nxt           = kind_r;
    xor_acc_nxt        = xor_acc_r;
    after_star_nxt     = after_star_r;
    rx_sum_nxt         = rx_sum_r;
    overflow_nxt       = overflow_r;
    res_valid          = 1'b0;
    res                = '0;
    fid                = FID_NONE;
    if (accept) begin
      if (c == CHAR_DOLLAR) begin
        in_sentence_nxt    = 1'b1;
        field_count_nxt    = '0;
        char_count_nxt     = '0;
        position_count_nxt = '0;
        format_chars_nxt   = '0;
        kind_nxt           = KIND_UNKNOWN;
        xor_acc_nxt        = '0;
        after_star_nxt     = 1'b0;
        rx_sum_nxt         = '0;
        overflow_nxt       = 1'b0;
      end else if (in_sentence_r) begin
        if (c == CHAR_CR) begin
          res_valid             = 1'b1;
          res.sentence_done     = 1'b1;
          res.sentence_kind     = kind_r;
          res.received_checksum = rx_sum_r;
          res.computed_checksum = xor_acc_r;
          res.overflow_seen     = overflow_r;
          in_sentence_nxt       = 1'b0;
        end else if (c == CHAR_LF) begin
          in_sentence_nxt = in_sentence_r;
        end else if (after_star_r) begin
          if (hex[4] && char_count_r < CSUM_DIGITS) begin
            rx_sum_nxt     = {rx_sum_r[3:0], hex[3:0]};
            char_count_nxt = char_count_r + 7'd1;
          end
        end else if (c == CHAR_STAR) begin
          after_star_nxt = 1'b1;
          char_count_nxt = '0;
          if (field_count_r < FIELD_COUNT_MAX) begin
            field_count_nxt = field_count_r + 4'd1;
          end
        end else begin
          xor_acc_nxt = xor_acc_r ^ c;
          if (c == CHAR_COMMA) begin
            char_count_nxt = '0;
            if (field_count_r < FIELD_COUNT_MAX) begin
              field_count_nxt = field_count_r + 4'd1;
            end
          end else begin
            if (field_count_r == FID_ADDRESS && position_count_r < ADDR_LEN) begin
              if (position_count_r >= ADDR_FMT_START) begin
                format_chars_nxt = fmt_shift;
              end
              position_count_nxt = position_count_r + 3'd1;
              if (position_count_r == ADDR_LAST_POS) begin
                if (fmt_shift == FMT_RMC) begin
                  kind_nxt = KIND_RMC;
                end else if (fmt_shift == FMT_GLL) begin
                  kind_nxt = KIND_GLL;
                end else begin
                  kind_nxt = KIND_UNKNOWN;
                end
              end
            end
            if (char_count_r >= FieldMax) begin
              overflow_nxt = 1'b1;
            end else begin
              if (char_count_r < CHAR_COUNT_MAX) begin
                char_count_nxt = char_count_r + 7'd1;
              end
              fid = map_field(field_count_r, kind_nxt);
              if (fid != FID_NONE) begin
                res_valid         = 1'b1;
                res.field_id      = fid;
                res.char_index    = char_count_r[5:0];
                res.char_value    = c;
                res.sentence_kind = kind_nxt;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sentence_r    <= 1'b0;
      field_count_r    <= '0;
      char_count_r     <= '0;
      position_count_r <= '0;
      format_chars_r   <= '0;
      kind_r           <= KIND_UNKNOWN;
      xor_acc_r        <= '0;
      after_star_r     <= 1'b0;
      rx_sum_r         <= '0;
      overflow_r       <= 1'b0;
    end else begin
      in_sentence_r    <= in_sentence_nxt;
      field_count_r    <= field_count_nxt;
      char_count_r     <= char_count_nxt;
      position_count_r <= position_count_nxt;
      format_chars_r   <= format_chars_nxt;
      kind_r           <= kind_nxt;
      xor_acc_r        <= xor_acc_nxt;
      after_star_r     <= after_star_nxt;
      rx_sum_r         <= rx_sum_nxt;
      overflow_r       <= overflow_nxt;
    end
  end

  assign out_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.field_id          = out_r.field_id;
  assign out_chan.char_index        = out_r.char_index;
  assign out_chan.char_value        = out_r.char_value;
  assign out_chan.sentence_done     = out_r.sentence_done;
  assign out_chan.sentence_kind     = out_r.sentence_kind;
  assign out_chan.received_checksum = out_r.received_checksum;
  assign out_chan.computed_checksum = out_r.computed_checksum;
  assign out_chan.overflow_seen     = out_r.overflow_seen;

endmodule

### rtl/core/nsfp_checker.sv
// Port-level assertions for the NMEA sentence field parser and the bind that
// attaches them to nmea_sentence_field_parser_core. Uses nsfp_pkg.
module nsfp_checker
  import nsfp_pkg::*;
#(
  parameter int FIELD_MAX_CHARS = 16
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_field_id,
  input logic [5:0] out_char_index,
  input logic [7:0] out_char_value,
  input logic       out_sentence_done,
  input logic [7:0] out_received_checksum,
  input logic [7:0] out_computed_checksum,
  input logic       out_overflow_seen
);

  localparam logic [6:0] FieldMax = 7'(FIELD_MAX_CHARS);

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_field_id) &&
      $stable(out_char_index) && $stable(out_char_value) && $stable(out_sentence_done))
    else $error("stalled result changed");

  a_index_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sentence_done |->
      {1'b0, out_char_index} < FieldMax && out_field_id != FID_NONE)
    else $error("character result beyond the field limit or without a field id");

  a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sentence_done |->
      out_received_checksum == 8'd0 && out_computed_checksum == 8'd0 && !out_overflow_seen)
    else $error("character result carries summary data");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sentence_done |->
      out_field_id == FID_ADDRESS && out_char_index == 6'd0 && out_char_value == 8'd0)
    else $error("end result carries character data");

endmodule

bind nmea_sentence_field_parser_core nsfp_checker #(
  .FIELD_MAX_CHARS(FIELD_MAX_CHARS)
) u_nsfp_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_chan.valid),
  .out_ready             (out_chan.ready),
  .out_field_id          (out_chan.field_id),
  .out_char_index        (out_chan.char_index),
  .out_char_value        (out_chan.char_value),
  .out_sentence_done     (out_chan.sentence_done),
  .out_received_checksum (out_chan.received_checksum),
  .out_computed_checksum (out_chan.computed_checksum),
  .out_overflow_seen     (out_chan.overflow_seen)
);
